// ===== rtl/fqr_pkg.sv =====
`default_nettype none

package fqr_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W     = 32;
    localparam int CMD_W     = 2;
    localparam int FILL_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH     = 2'd0,
        CMD_POP      = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_CONTAINS = 2'd3
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/fqr_if.sv =====
`default_nettype none

// Request channel: command and key
interface fqr_in_if;
    logic                      valid;
    logic                      ready;
    logic [fqr_pkg::CMD_W-1:0] cmd;
    logic [fqr_pkg::KEY_W-1:0] key_value;

    modport source (output valid, output cmd, output key_value, input ready);
    modport sink   (input valid, input cmd, input key_value, output ready);
endinterface

// Response channel: popped value, flags and length
interface fqr_out_if;
    logic                       valid;
    logic                       ready;
    logic [fqr_pkg::KEY_W-1:0]  out_value;
    logic                       hit;
    logic                       overflow;
    logic                       is_empty;
    logic [fqr_pkg::FILL_W-1:0] fill_count;

    modport source (output valid, output out_value, output hit, output overflow,
                    output is_empty, output fill_count, input ready);
    modport sink   (input valid, input out_value, input hit, input overflow,
                    input is_empty, input fill_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/fqr_ram.sv =====
`default_nettype none

module fqr_ram #(
    parameter int WIDTH = fqr_pkg::KEY_W,
    parameter int DEPTH = fqr_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fifo_queue_with_remove.sv =====
// Channel   Dir  Fields                                         Handshake
// i_in      in   cmd, key_value                                 valid/ready
// o_out     out  out_value, hit, overflow, is_empty, fill_count valid/ready
//
// One item at a time: push writes straight to the tail; pop, remove and contains
// walk the entry RAM through its single read port, one entry a cycle; pop and
// remove then close the gap with one read and one write a cycle.
// Synchronous active-low reset empties the queue; the RAM is not cleared.
// A result waiting in the output register does not block the next request;
// only the handover of the following result waits for o_out.ready.
`default_nettype none

module fifo_queue_with_remove #(
    parameter int DEPTH = fqr_pkg::DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fqr_in_if.sink    i_in,
    fqr_out_if.source o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    t_state                     r_state,  n_state;
    fqr_pkg::t_cmd              r_cmd,    n_cmd;
    logic [fqr_pkg::KEY_W-1:0]  r_key,    n_key;
    logic [CW-1:0]              r_count,  n_count;
    logic [CW-1:0]              r_ri,     n_ri;
    logic [CW-1:0]              r_di,     n_di;
    logic                       r_dv,     n_dv;
    logic                       r_hit,    n_hit;
    logic                       r_ovf,    n_ovf;
    logic [fqr_pkg::KEY_W-1:0]  r_val,    n_val;
    logic                       r_ovld,   n_ovld;
    logic [fqr_pkg::KEY_W-1:0]  r_o_val,  n_o_val;
    logic                       r_o_hit,  n_o_hit;
    logic                       r_o_ovf,  n_o_ovf;
    logic                       r_o_emp,  n_o_emp;
    logic [fqr_pkg::FILL_W-1:0] r_o_fill, n_o_fill;

    logic                       accept;
    fqr_pkg::t_cmd              in_cmd;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [fqr_pkg::KEY_W-1:0]  ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [fqr_pkg::KEY_W-1:0]  ram_rdata;
    logic                       match;
    logic                       walk_rd;
    logic [CW-1:0]              di_dec;

    fqr_ram #(
        .WIDTH (fqr_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign in_cmd     = fqr_pkg::t_cmd'(i_in.cmd);

    // The single comparator: pop takes whatever sits at the head
    assign match   = (r_cmd == fqr_pkg::CMD_POP) || (ram_rdata == r_key);
    assign walk_rd = (r_state inside {S_SCAN, S_SHIFT}) && (r_ri < r_count);
    assign di_dec  = r_di - CW'(1);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_count  = r_count;
        n_ri     = r_ri;
        n_di     = r_di;
        n_dv     = r_dv;
        n_hit    = r_hit;
        n_ovf    = r_ovf;
        n_val    = r_val;
        n_ovld   = r_ovld;
        n_o_val  = r_o_val;
        n_o_hit  = r_o_hit;
        n_o_ovf  = r_o_ovf;
        n_o_emp  = r_o_emp;
        n_o_fill = r_o_fill;

        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = i_in.key_value;
        ram_re    = 1'b0;
        ram_raddr = r_ri[AW-1:0];

        if (r_ovld && o_out.ready) begin
            n_ovld = 1'b0;
        end

        // Walk reads: one entry a cycle, valid flag follows the RAM latency
        if (walk_rd) begin
            ram_re = 1'b1;
            n_ri   = r_ri + CW'(1);
        end
        if (r_state inside {S_SCAN, S_SHIFT}) begin
            n_dv = walk_rd;
            n_di = r_ri;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = in_cmd;
                    n_key = i_in.key_value;
                    n_hit = 1'b0;
                    n_ovf = 1'b0;
                    n_val = '0;
                    if (in_cmd == fqr_pkg::CMD_PUSH) begin
                        if (r_count < CW'(DEPTH)) begin
                            ram_we  = 1'b1;
                            n_count = r_count + CW'(1);
                            n_hit   = 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_state = S_RESP;
                    end else begin
                        // Fetch the head; an empty queue leaves the data flag low
                        ram_re    = (r_count != '0);
                        ram_raddr = '0;
                        n_dv      = (r_count != '0);
                        n_di      = '0;
                        n_ri      = CW'(1);
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!r_dv) begin
                    n_state = S_RESP;
                end else if (match) begin
                    n_hit = 1'b1;
                    if (r_cmd == fqr_pkg::CMD_POP) begin
                        n_val = ram_rdata;
                    end
                    if (r_cmd == fqr_pkg::CMD_CONTAINS) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (r_dv) begin
                    // Move the entry one place towards the head
                    ram_we    = 1'b1;
                    ram_waddr = di_dec[AW-1:0];
                    ram_wdata = ram_rdata;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_ovld || o_out.ready) begin
                    n_ovld   = 1'b1;
                    n_o_val  = r_val;
                    n_o_hit  = r_hit;
                    n_o_ovf  = r_ovf;
                    n_o_emp  = (r_count == '0);
                    n_o_fill = fqr_pkg::FILL_W'(r_count);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_ovld  <= n_ovld;
        end
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_ri     <= n_ri;
        r_di     <= n_di;
        r_hit    <= n_hit;
        r_ovf    <= n_ovf;
        r_val    <= n_val;
        r_o_val  <= n_o_val;
        r_o_hit  <= n_o_hit;
        r_o_ovf  <= n_o_ovf;
        r_o_emp  <= n_o_emp;
        r_o_fill <= n_o_fill;
    end

    assign o_out.valid      = r_ovld;
    assign o_out.out_value  = r_o_val;
    assign o_out.hit        = r_o_hit;
    assign o_out.overflow   = r_o_ovf;
    assign o_out.is_empty   = r_o_emp;
    assign o_out.fill_count = r_o_fill;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full_push_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_cmd == fqr_pkg::CMD_PUSH) && (r_count == CW'(DEPTH)))
        |=> ($stable(r_count) && r_ovf && !r_hit))
        else $error("push into full queue changed the count");

    a_write_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == S_SHIFT)) |-> (di_dec < r_count))
        else $error("gap closing wrote beyond the tail");

    a_hit_ovf_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> !(r_o_hit && r_o_ovf))
        else $error("result flags both hit and overflow");

    a_no_stall_loss : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !o_out.ready) |=> r_ovld)
        else $error("stalled result dropped");

endmodule

`default_nettype wire
